/* hw/rtl/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 package
// S-box, system parameters, round constants and the round functions used by
// the key schedule and by the data pipeline.
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned NRounds = 32;
  localparam int unsigned RkIdxW  = 5;

  typedef logic [WordW-1:0] word_t;
  typedef logic [HalfW-1:0] half_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  // Byte j of round constant i is (4*i + j) * 7 mod 256.
  function automatic word_t round_const(input logic [RkIdxW-1:0] idx);
    logic [7:0] b0, b1, b2, b3, base;
    base = {idx, 2'b00};
    b0 = 8'((base + 8'd0) * 8'd7);
    b1 = 8'((base + 8'd1) * 8'd7);
    b2 = 8'((base + 8'd2) * 8'd7);
    b3 = 8'((base + 8'd3) * 8'd7);
    return {b0, b1, b2, b3};
  endfunction

  function automatic word_t sub_word(input word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  function automatic word_t key_mix(input word_t x);
    word_t b;
    b = sub_word(x);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  function automatic word_t data_mix(input word_t x);
    word_t b;
    b = sub_word(x);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

endpackage

/* hw/rtl/sm4_stream_if.sv */
// ----------------------------------------------------------------------------
// SM4 stream interfaces
// Valid/ready channels for the input blocks and the result blocks.
// ----------------------------------------------------------------------------
interface sm4_in_if;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  sm4_pkg::half_t       block_high;
  sm4_pkg::half_t       block_low;
  modport source (output valid, cmd, block_high, block_low, input ready);
  modport sink   (input valid, cmd, block_high, block_low, output ready);
endinterface

interface sm4_out_if;
  logic                 valid;
  logic                 ready;
  sm4_pkg::half_t       result_high;
  sm4_pkg::half_t       result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

/* hw/rtl/sm4_key_sched.sv */
// ----------------------------------------------------------------------------
// SM4 key schedule
// Expands the key registers into 32 round keys, one key word per cycle.
// A new key restarts the expansion; keys_ok_o rises when all are ready.
// ----------------------------------------------------------------------------
module sm4_key_sched (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    restart_i,
  input  logic [127:0]            key_i,
  output logic                    keys_ok_o,
  output sm4_pkg::word_t          rk_o [sm4_pkg::NRounds]
);

  sm4_pkg::word_t                 k_q [4];
  sm4_pkg::word_t                 k_d [4];
  sm4_pkg::word_t                 rk_q [sm4_pkg::NRounds];
  logic [sm4_pkg::RkIdxW:0]       cnt_q, cnt_d;
  sm4_pkg::word_t                 nxt;

  assign nxt = k_q[0] ^ sm4_pkg::key_mix(k_q[1] ^ k_q[2] ^ k_q[3] ^
               sm4_pkg::round_const(cnt_q[sm4_pkg::RkIdxW-1:0]));

  always_comb begin
    k_d   = k_q;
    cnt_d = cnt_q;
    if (restart_i) begin
      for (int i = 0; i < 4; i++) begin
        k_d[i] = key_i[127-32*i -: 32] ^ sm4_pkg::FK[i];
      end
      cnt_d = '0;
    end else if (!cnt_q[sm4_pkg::RkIdxW]) begin
      k_d   = '{k_q[1], k_q[2], k_q[3], nxt};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < 4; i++) begin
        k_q[i] <= sm4_pkg::FK[i];
      end
    end else begin
      cnt_q <= cnt_d;
      k_q   <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!restart_i && !cnt_q[sm4_pkg::RkIdxW]) begin
      rk_q[cnt_q[sm4_pkg::RkIdxW-1:0]] <= nxt;
    end
  end

  assign keys_ok_o = cnt_q[sm4_pkg::RkIdxW];
  assign rk_o      = rk_q;

endmodule

/* hw/rtl/sm4_round.sv */
// ----------------------------------------------------------------------------
// SM4 round stage
// One registered cipher round with its own valid bit and stall control.
// ----------------------------------------------------------------------------
module sm4_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic                    cmd_i,
  input  logic [127:0]            x_i,
  input  sm4_pkg::word_t          rk_i,
  output logic                    valid_o,
  output logic                    cmd_o,
  output logic [127:0]            x_o
);

  logic            valid_q;
  logic            cmd_q;
  logic [127:0]    x_q, x_d;

  assign x_d = {x_i[95:0], x_i[127:96] ^ sm4_pkg::data_mix(x_i[95:64] ^ x_i[63:32] ^
                x_i[31:0] ^ rk_i)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;
  assign x_o     = x_q;

endmodule

/* hw/rtl/sm4_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// SM4 block cipher top
// ECB engine with a 32-stage round pipeline and an iterative key schedule.
// ----------------------------------------------------------------------------
// Each block passes 32 round stages and one output register. The first round
// stage captures a block at the edge that takes its beat; the block then moves
// through the remaining round stages into the output register, which presents
// the result. A new block is taken every cycle while the output side keeps up,
// and a whole-pipe stall holds every stage. After reset and after each key
// register write the key schedule restarts in the following cycle and then
// computes the 32 round keys, one per cycle. No input is taken in that time, so
// the first beat under a new key is taken only once every round key is ready.
module sm4_block_cipher_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [63:0]   cfg_data_i,
  sm4_in_if.sink        in_if,
  sm4_out_if.source     out_if
);

  localparam int unsigned N = sm4_pkg::NRounds;

  sm4_pkg::half_t       key_high_q, key_low_q;
  logic                 keys_ok;
  logic                 restart;
  sm4_pkg::word_t       rk [N];
  logic                 adv;
  logic                 v   [N+1];
  logic                 c   [N+1];
  logic [127:0]         x   [N+1];
  logic                 out_valid_q;
  logic [127:0]         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (sm4_pkg::reg_idx_e'(cfg_idx_i))
        sm4_pkg::REG_KEY_HIGH: key_high_q <= cfg_data_i;
        sm4_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Restart only when the register write has landed.
  logic cfg_we_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_we_q <= 1'b1;
    end else begin
      cfg_we_q <= cfg_we_i;
    end
  end
  assign restart = cfg_we_q;

  sm4_key_sched u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (restart),
    .key_i     ({key_high_q, key_low_q}),
    .keys_ok_o (keys_ok),
    .rk_o      (rk)
  );

  assign adv          = !out_valid_q || out_if.ready;
  assign in_if.ready  = adv && keys_ok && !restart && !cfg_we_i;
  assign v[0] = in_if.valid && in_if.ready;
  assign c[0] = in_if.cmd;
  assign x[0] = {in_if.block_high, in_if.block_low};

  for (genvar g = 0; g < N; g++) begin : g_round
    sm4_pkg::word_t rk_sel;
    assign rk_sel = c[g] ? rk[N-1-g] : rk[g];
    sm4_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v[g]),
      .cmd_i   (c[g]),
      .x_i     (x[g]),
      .rk_i    (rk_sel),
      .valid_o (v[g+1]),
      .cmd_o   (c[g+1]),
      .x_o     (x[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {x[N][31:0], x[N][63:32], x[N][95:64], x[N][127:96]};
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.result_high = out_q[127:64];
  assign out_if.result_low  = out_q[63:0];

`ifndef NO_ASSERTIONS
  a_no_accept_without_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> keys_ok)
    else $error("beat taken while round keys not ready");
  a_stall_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_q)))
    else $error("result lost under stall");
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |-> !in_if.ready)
    else $error("beat taken while pipe stalled");
`endif

endmodule

/* bench/tb_sm4_block_cipher_top.sv */
// ----------------------------------------------------------------------------
// SM4 block cipher top testbench
// Drives ECB blocks through the cipher under several keys, with bursty input
// and a stalling output, and checks every result block against an SM4 model or a known value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sm4_block_cipher_top;

  typedef struct packed {
    sm4_pkg::cmd_e  cmd;
    sm4_pkg::half_t block_high;
    sm4_pkg::half_t block_low;
  } block_req_t;

  typedef struct packed {
    sm4_pkg::half_t result_high;
    sm4_pkg::half_t result_low;
  } block_res_t;

  localparam logic [7:0] SUB [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };
  localparam sm4_pkg::word_t SYS_PARAM [4] =
    '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};
  localparam sm4_pkg::half_t ONES = '1;
  localparam int unsigned RandBlocks = 1820;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  sm4_pkg::reg_idx_e cfg_idx_i = sm4_pkg::REG_KEY_HIGH;
  sm4_pkg::half_t cfg_data_i = '0;

  sm4_in_if  in_if ();
  sm4_out_if out_if ();

  sm4_block_cipher_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sm4_pkg::half_t cur_key_high = '0;
  sm4_pkg::half_t cur_key_low = '0;
  block_res_t pending_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit stall_fast = 1'b0;

  function automatic sm4_pkg::word_t rol(input sm4_pkg::word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic sm4_pkg::word_t tau(input sm4_pkg::word_t x);
    return {SUB[x[31:24]], SUB[x[23:16]], SUB[x[15:8]], SUB[x[7:0]]};
  endfunction

  function automatic block_res_t sm4_cipher(input block_req_t req);
    sm4_pkg::word_t rk [32];
    sm4_pkg::word_t k [4];
    sm4_pkg::word_t x [4];
    sm4_pkg::word_t t, ck, nw;
    for (int i = 0; i < 4; i++) begin
      k[i] = (i < 2 ? (i == 0 ? cur_key_high[63:32] : cur_key_high[31:0])
                    : (i == 2 ? cur_key_low[63:32] : cur_key_low[31:0])) ^ SYS_PARAM[i];
    end
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4 * i + j) * 7);
      t = tau(k[1] ^ k[2] ^ k[3] ^ ck);
      nw = k[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      rk[i] = nw;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nw;
    end
    x[0] = req.block_high[63:32];
    x[1] = req.block_high[31:0];
    x[2] = req.block_low[63:32];
    x[3] = req.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      t = tau(x[1] ^ x[2] ^ x[3] ^
              (req.cmd == sm4_pkg::CMD_DECRYPT ? rk[31 - i] : rk[i]));
      nw = x[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nw;
    end
    return '{result_high: {x[3], x[2]}, result_low: {x[1], x[0]}};
  endfunction

  task automatic write_key(input sm4_pkg::reg_idx_e idx, input sm4_pkg::half_t value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sm4_pkg::REG_KEY_HIGH) cur_key_high = value;
    else cur_key_low = value;
    @(posedge clk_i);
  endtask

  // Sends one block once the cipher takes it, with a random gap in front of some bursts.
  int unsigned burst_left = 0;
  task automatic send_block(input block_req_t req, input bit has_known,
                            input block_res_t known);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      burst_left = $urandom_range(1, 40);
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.cmd        <= req.cmd;
    in_if.block_high <= req.block_high;
    in_if.block_low  <= req.block_low;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(has_known ? known : sm4_cipher(req));
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Output side: stall pattern switches between heavy and none per phase.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h %h", out_if.result_high, out_if.result_low);
        fail_count++;
      end else begin
        block_res_t want;
        want = pending_results.pop_front();
        if (out_if.result_high !== want.result_high) begin
          $error("result_high: expected %h, actual %h", want.result_high, out_if.result_high);
          fail_count++;
        end
        if (out_if.result_low !== want.result_low) begin
          $error("result_low: expected %h, actual %h", want.result_low, out_if.result_low);
          fail_count++;
        end
      end
    end
    out_if.ready <= stall_fast ? 1'b1 : (($urandom_range(0, 9) < 6) || cycle_count[5]);
  end

  typedef struct {
    block_req_t req;
    bit         has_known;
    block_res_t known;
  } stim_row_t;

  stim_row_t directed [] = '{
    // Standard test vector under the zero key set below is not easily read;
    // the all-zero and all-one blocks rely on the model.
    '{'{sm4_pkg::CMD_ENCRYPT, 64'h0, 64'h0}, 1'b0, '0},
    '{'{sm4_pkg::CMD_DECRYPT, 64'h0, 64'h0}, 1'b0, '0},
    '{'{sm4_pkg::CMD_ENCRYPT, ONES, ONES}, 1'b0, '0},
    '{'{sm4_pkg::CMD_DECRYPT, ONES, ONES}, 1'b0, '0},
    '{'{sm4_pkg::CMD_ENCRYPT, ONES, 64'h0}, 1'b0, '0},
    '{'{sm4_pkg::CMD_DECRYPT, 64'h0, ONES}, 1'b0, '0},
    '{'{sm4_pkg::CMD_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210}, 1'b0, '0},
    '{'{sm4_pkg::CMD_DECRYPT, 64'h8000000000000001, 64'h8000000000000001}, 1'b0, '0}
  };

  // Published SM4 example: key and plaintext 0123456789abcdeffedcba9876543210.
  localparam sm4_pkg::half_t VecHigh = 64'h0123456789abcdef;
  localparam sm4_pkg::half_t VecLow  = 64'hfedcba9876543210;
  localparam block_res_t VecCipher = '{64'h681edf34d206965e, 64'h86b3e94f536e4246};

  initial begin
    block_req_t r;
    in_if.valid = 1'b0;
    in_if.cmd = sm4_pkg::CMD_ENCRYPT;
    in_if.block_high = '0;
    in_if.block_low = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key of zero.
    foreach (directed[i]) send_block(directed[i].req, directed[i].has_known, directed[i].known);
    drain();

    write_key(sm4_pkg::REG_KEY_HIGH, VecHigh);
    write_key(sm4_pkg::REG_KEY_LOW, VecLow);
    send_block('{sm4_pkg::CMD_ENCRYPT, VecHigh, VecLow}, 1'b1, VecCipher);
    send_block('{sm4_pkg::CMD_DECRYPT, VecCipher.result_high, VecCipher.result_low}, 1'b1,
               '{VecHigh, VecLow});
    foreach (directed[i]) send_block(directed[i].req, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_key(sm4_pkg::REG_KEY_HIGH, ONES);
          write_key(sm4_pkg::REG_KEY_LOW, ONES);
        end
        1: begin write_key(sm4_pkg::REG_KEY_LOW, '0); end
        2: begin
          write_key(sm4_pkg::REG_KEY_HIGH, '0);
          write_key(sm4_pkg::REG_KEY_LOW, ONES);
        end
        default: begin
          write_key(sm4_pkg::REG_KEY_HIGH, {$urandom, $urandom});
          write_key(sm4_pkg::REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      stall_fast = phase[0];
      for (int n = 0; n < RandBlocks / 6; n++) begin
        r.cmd = sm4_pkg::cmd_e'($urandom_range(0, 1));
        r.block_high = {$urandom, $urandom};
        r.block_low = {$urandom, $urandom};
        send_block(r, 1'b0, '0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
